@@ rtl/bhq_pkg.sv @@
// ============================================================================
// Heap queue shared definitions
// Key and count widths, operation codes and result status codes used by the
// heap queue, its channel interfaces and its level cells.
// ============================================================================
package bhq_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ rtl/bhq_req_if.sv @@
// ============================================================================
// Heap queue request channel
// Valid/ready channel that carries one operation and its key per transfer.
// ============================================================================
interface bhq_req_if;
  logic                                valid;
  logic                                ready;
  bhq_pkg::cmd_e                       cmd;
  logic signed [bhq_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, output cmd, output key_value, input ready);
  modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

@@ rtl/bhq_rsp_if.sv @@
// ============================================================================
// Heap queue response channel
// Valid/ready channel that carries one operation result per transfer.
// ============================================================================
interface bhq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [bhq_pkg::KEY_W-1:0]    popped_key;
  bhq_pkg::status_e                    status;
  logic [bhq_pkg::COUNT_W-1:0]         count_after;

  modport source (output valid, output popped_key, output status, output count_after,
                  input ready);
  modport sink   (input valid, input popped_key, input status, input count_after,
                  output ready);
endinterface

@@ rtl/bhq_cell.sv @@
// ============================================================================
// Heap queue level cell
// Holds one level of the heap as sibling pairs and moves the sift token one
// level further down: it first reads the pair into its read registers, then
// compares, writes and hands the token on to the next cell.
// ============================================================================
module bhq_cell #(
  parameter int unsigned LEVEL = 0,
  parameter int unsigned ROWS  = 1,
  parameter int unsigned POS_W = 1,
  parameter int unsigned CNT_W = 2,
  parameter int unsigned LVL_W = 1,
  parameter type         tok_t = logic,
  parameter type         wr_t  = logic
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tok_t                      tok_i,
  output tok_t                      tok_o,
  input  wr_t                       wb_i,
  output wr_t                       wb_o,
  input  logic                      fetch_i,
  input  logic [POS_W-1:0]          fetch_pos_i,
  output logic [bhq_pkg::KEY_W-1:0] rd_even_o,
  output logic [bhq_pkg::KEY_W-1:0] rd_odd_o,
  output logic                      done_o
);

  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned GLB_W = CNT_W + 2;
  localparam logic [GLB_W-1:0] BASE   = GLB_W'((1 << LEVEL) - 1);
  localparam logic [LVL_W-1:0] MY_LVL = LVL_W'(LEVEL);

  logic [bhq_pkg::KEY_W-1:0] mem_even_q [ROWS];
  logic [bhq_pkg::KEY_W-1:0] mem_odd_q  [ROWS];
  logic [bhq_pkg::KEY_W-1:0] rd_even_q, rd_odd_q;

  tok_t tok_q, tok_d, tok_out_q;
  wr_t  own_wr, wr_sel;

  logic                 rd_en;
  logic [POS_W-1:0]     rd_pos, rd_row_full, wr_row_full;
  logic [ROW_W-1:0]     rd_row, wr_row;

  logic [GLB_W-1:0]          left, right, child, grand, num_g;
  logic                      left_ok, right_ok, sel, gc_ok, path_bit;
  logic [bhq_pkg::KEY_W-1:0] big, node;
  logic [POS_W-1:0]          child_pos, ins_pos;
  logic [LVL_W-1:0]          path_idx;

  // Delete tokens address a row (the parent's position); insert tokens and
  // fetches address a single position.
  assign rd_en       = fetch_i || tok_i.valid;
  assign rd_pos      = fetch_i ? fetch_pos_i : tok_i.pos;
  assign rd_row_full = (tok_i.del && !fetch_i) ? tok_i.pos : (rd_pos >> 1);
  assign rd_row      = rd_row_full[ROW_W-1:0];

  assign wr_sel      = own_wr.valid ? own_wr : wb_i;
  assign wr_row_full = wr_sel.pos >> 1;
  assign wr_row      = wr_row_full[ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_even_q <= mem_even_q[rd_row];
      rd_odd_q  <= mem_odd_q[rd_row];
    end
    if (wr_sel.valid && !wr_sel.pos[0]) begin
      mem_even_q[wr_row] <= wr_sel.key;
    end
    if (wr_sel.valid && wr_sel.pos[0]) begin
      mem_odd_q[wr_row] <= wr_sel.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      tok_out_q <= '0;
    end else begin
      tok_q     <= tok_i;
      tok_out_q <= tok_d;
    end
  end

  // Child bookkeeping in global heap indices.
  assign num_g     = GLB_W'(tok_q.num);
  assign left      = BASE + (GLB_W'(tok_q.pos) << 1);
  assign right     = left + GLB_W'(1);
  assign left_ok   = left < num_g;
  assign right_ok  = right < num_g;
  assign sel       = right_ok && ($signed(rd_odd_q) > $signed(rd_even_q));
  assign big       = sel ? rd_odd_q : rd_even_q;
  assign child     = left + GLB_W'(sel);
  assign grand     = (child << 1) + GLB_W'(1);
  assign gc_ok     = grand < num_g;
  assign child_pos = (tok_q.pos << 1) | POS_W'(sel);

  // Insert path: the bits of the target slot number plus one below its leading one.
  assign node      = tok_q.pos[0] ? rd_odd_q : rd_even_q;
  assign path_idx  = tok_q.lvl - MY_LVL - LVL_W'(1);
  assign path_bit  = tok_q.num[path_idx];
  assign ins_pos   = (tok_q.pos << 1) | POS_W'(path_bit);

  always_comb begin
    tok_d       = tok_q;
    tok_d.valid = 1'b0;
    own_wr      = '0;
    wb_o        = '0;
    done_o      = 1'b0;
    if (tok_q.valid) begin
      if (tok_q.del) begin
        wb_o.valid = 1'b1;
        wb_o.pos   = tok_q.pos;
        if (left_ok && ($signed(big) > $signed(tok_q.key))) begin
          wb_o.key = big;
          if (gc_ok) begin
            tok_d.valid = 1'b1;
            tok_d.pos   = child_pos;
          end else begin
            own_wr.valid = 1'b1;
            own_wr.pos   = child_pos;
            own_wr.key   = tok_q.key;
            done_o       = 1'b1;
          end
        end else begin
          wb_o.key = tok_q.key;
          done_o   = 1'b1;
        end
      end else if (tok_q.lvl == MY_LVL) begin
        own_wr.valid = 1'b1;
        own_wr.pos   = tok_q.pos;
        own_wr.key   = tok_q.key;
        done_o       = 1'b1;
      end else begin
        tok_d.valid = 1'b1;
        tok_d.pos   = ins_pos;
        if ($signed(tok_q.key) > $signed(node)) begin
          own_wr.valid = 1'b1;
          own_wr.pos   = tok_q.pos;
          own_wr.key   = tok_q.key;
          tok_d.key    = node;
        end
      end
    end
  end

  assign tok_o     = tok_out_q;
  assign rd_even_o = rd_even_q;
  assign rd_odd_o  = rd_odd_q;

endmodule

@@ rtl/binary_max_heap_queue.sv @@
// ============================================================================
// Binary max-heap priority queue
// Bounded max-heap of signed keys. Each request inserts a key or removes the
// largest one, and each request gives exactly one response.
// ============================================================================
//
//   Channel  Dir  Transfer contents
//   -------  ---  ----------------------------------------------------------
//   req_i    in   cmd (insert / delete maximum), key_value
//   rsp_o    out  popped_key, status (ok / empty / full), count_after
//
// An insert gives its response once its key has come down the chain of level
// cells to the level of the new slot; a delete first fetches the root and the
// last key and gives its response once the moved key comes to rest. Both are
// set by the chain of level cells, each first reading a sibling pair from its
// memory and then comparing and writing. The request channel takes one
// request at a time and may accept the next one while the previous response
// still waits on rsp_o. Reset clears the key count and the control
// registers; the key storage needs no clearing since only slots below the
// count are read.
// ============================================================================
module binary_max_heap_queue #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bhq_req_if.sink     req_i,
  bhq_rsp_if.source   rsp_o
);

  // Count width and number of heap levels are the same figure.
  localparam int unsigned CW     = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned LEVELS = CW;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned PW     = LEVELS - 1;
  localparam int unsigned KW     = bhq_pkg::KEY_W;
  localparam int unsigned OW     = bhq_pkg::COUNT_W;

  // Sift token that travels down the chain of level cells. For an insert, num
  // holds the new slot number plus one (its bits steer the path) and lvl the
  // target level; for a delete, num holds the count after the removal.
  typedef struct packed {
    logic                 valid;
    logic                 del;
    logic [PW-1:0]        pos;
    logic signed [KW-1:0] key;
    logic [CW-1:0]        num;
    logic [LW-1:0]        lvl;
  } tok_t;

  // Single-entry write into a level; used for a cell's own writes and for write-backs to the level above.
  typedef struct packed {
    logic                 valid;
    logic [PW-1:0]        pos;
    logic signed [KW-1:0] key;
  } wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_RUN,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]       cnt_q, cnt_d;
  tok_t                launch_q, launch_d, ins_launch, del_launch;
  logic [LW-1:0]       fetch_lvl_q, fetch_lvl_d;
  logic [PW-1:0]       fetch_pos_q, fetch_pos_d;
  logic                fetch_en;

  logic [KW-1:0]       pend_key_q, pend_key_d;
  bhq_pkg::status_e    pend_st_q, pend_st_d;
  logic [CW-1:0]       pend_cnt_q, pend_cnt_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [KW-1:0]       rsp_key_q, rsp_key_d;
  bhq_pkg::status_e    rsp_st_q, rsp_st_d;
  logic [OW-1:0]       rsp_cnt_q, rsp_cnt_d;
  logic [CW+OW-1:0]    cnt_ext;

  logic [CW-1:0]       ins_num, del_clear;
  logic [LW-1:0]       ins_lvl, del_lvl;
  logic [PW-1:0]       del_pos;
  logic [KW-1:0]       last_key;

  tok_t                tok_out [LEVELS];
  wr_t                 wb_up   [LEVELS];
  logic [KW-1:0]       rd_even [LEVELS];
  logic [KW-1:0]       rd_odd  [LEVELS];
  logic [LEVELS-1:0]   done_vec;
  logic [LEVELS-1:0]   fetch_vec;

  // Position of the leading one, which is the heap level of a slot whose
  // number plus one is given.
  function automatic logic [LW-1:0] lead_one(input logic [CW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Chain of level cells. Level c holds 2^c slots (fewer on the last level),
  // stored as sibling pairs so that a delete reads both children at once.
  // --------------------------------------------------------------------------
  always_comb begin
    ins_launch       = launch_q;
    ins_launch.valid = launch_q.valid && !launch_q.del;
    del_launch       = launch_q;
    del_launch.valid = launch_q.valid && launch_q.del;
  end

  assign fetch_en = (state_q == S_FETCH);

  for (genvar c = 0; c < LEVELS; c++) begin : g_lvl
    localparam int unsigned SPAN = 1 << c;
    localparam int unsigned FREE = HEAP_DEPTH + 1 - SPAN;
    localparam int unsigned USED = (SPAN < FREE) ? SPAN : FREE;
    localparam int unsigned ROWS = (USED + 1) / 2;

    tok_t          tin;
    wr_t           wbin;
    logic [PW-1:0] fpos;

    if (c == 0) begin : g_root
      assign tin  = ins_launch;
      assign fpos = '0;
    end else if (c == 1) begin : g_first
      assign tin  = tok_out[0].valid ? tok_out[0] : del_launch;
      assign fpos = fetch_pos_q;
    end else begin : g_inner
      assign tin  = tok_out[c-1];
      assign fpos = fetch_pos_q;
    end

    if (c == LEVELS - 1) begin : g_last
      assign wbin = '0;
    end else begin : g_wb
      assign wbin = wb_up[c+1];
    end

    // The root and the level of the last slot are read together on a delete.
    assign fetch_vec[c] = fetch_en && ((c == 0) || (fetch_lvl_q == LW'(c)));

    bhq_cell #(
      .LEVEL (c),
      .ROWS  (ROWS),
      .POS_W (PW),
      .CNT_W (CW),
      .LVL_W (LW),
      .tok_t (tok_t),
      .wr_t  (wr_t)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tin),
      .tok_o       (tok_out[c]),
      .wb_i        (wbin),
      .wb_o        (wb_up[c]),
      .fetch_i     (fetch_vec[c]),
      .fetch_pos_i (fpos),
      .rd_even_o   (rd_even[c]),
      .rd_odd_o    (rd_odd[c]),
      .done_o      (done_vec[c])
    );
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  assign ins_num   = cnt_q + CW'(1);
  assign ins_lvl   = lead_one(ins_num);
  assign del_lvl   = lead_one(cnt_q);
  assign del_clear = cnt_q & ~(CW'(1) << del_lvl);
  assign del_pos   = del_clear[PW-1:0];
  assign last_key  = fetch_pos_q[0] ? rd_odd[fetch_lvl_q] : rd_even[fetch_lvl_q];
  assign cnt_ext   = {OW'(0), pend_cnt_q};

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    launch_d       = launch_q;
    launch_d.valid = 1'b0;
    fetch_lvl_d    = fetch_lvl_q;
    fetch_pos_d    = fetch_pos_q;
    pend_key_d     = pend_key_q;
    pend_st_d      = pend_st_q;
    pend_cnt_d     = pend_cnt_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    rsp_key_d      = rsp_key_q;
    rsp_st_d       = rsp_st_q;
    rsp_cnt_d      = rsp_cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          pend_key_d = '0;
          if (req_i.cmd == bhq_pkg::CMD_INSERT) begin
            if (cnt_q == CW'(HEAP_DEPTH)) begin
              // Heap is full: the key is dropped and nothing changes.
              pend_st_d  = bhq_pkg::ST_FULL;
              pend_cnt_d = cnt_q;
              state_d    = S_FIN;
            end else begin
              launch_d.valid = 1'b1;
              launch_d.del   = 1'b0;
              launch_d.pos   = '0;
              launch_d.key   = req_i.key_value;
              launch_d.num   = ins_num;
              launch_d.lvl   = ins_lvl;
              cnt_d          = ins_num;
              pend_st_d      = bhq_pkg::ST_OK;
              pend_cnt_d     = ins_num;
              state_d        = S_RUN;
            end
          end else begin
            if (cnt_q == '0) begin
              // Heap is empty: report it and leave the state alone.
              pend_st_d  = bhq_pkg::ST_EMPTY;
              pend_cnt_d = '0;
              state_d    = S_FIN;
            end else begin
              fetch_lvl_d = del_lvl;
              fetch_pos_d = del_pos;
              cnt_d       = cnt_q - CW'(1);
              pend_st_d   = bhq_pkg::ST_OK;
              pend_cnt_d  = cnt_q - CW'(1);
              state_d     = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        // The root is the result; the last key restarts from the root and
        // sifts down through the chain, beginning with the root's children.
        pend_key_d = rd_even[0];
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          launch_d.valid = 1'b1;
          launch_d.del   = 1'b1;
          launch_d.pos   = '0;
          launch_d.key   = last_key;
          launch_d.num   = cnt_q;
          launch_d.lvl   = '0;
          state_d        = S_RUN;
        end
      end
      S_RUN: begin
        if (|done_vec) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_key_d   = pend_key_q;
          rsp_st_d    = pend_st_q;
          rsp_cnt_d   = cnt_ext[OW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      launch_q    <= '0;
      fetch_lvl_q <= '0;
      fetch_pos_q <= '0;
      pend_key_q  <= '0;
      pend_st_q   <= bhq_pkg::ST_OK;
      pend_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
      rsp_key_q   <= '0;
      rsp_st_q    <= bhq_pkg::ST_OK;
      rsp_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      launch_q    <= launch_d;
      fetch_lvl_q <= fetch_lvl_d;
      fetch_pos_q <= fetch_pos_d;
      pend_key_q  <= pend_key_d;
      pend_st_q   <= pend_st_d;
      pend_cnt_q  <= pend_cnt_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_key_q   <= rsp_key_d;
      rsp_st_q    <= rsp_st_d;
      rsp_cnt_q   <= rsp_cnt_d;
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.popped_key  = rsp_key_q;
  assign rsp_o.status      = rsp_st_q;
  assign rsp_o.count_after = rsp_cnt_q;

endmodule
